@@ src/dmt_pkg.sv @@
package dmt_pkg;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // register indexes
   localparam logic [1:0] REG_DIV  = 2'd0;
   localparam logic [1:0] REG_TIMA = 2'd1;
   localparam logic [1:0] REG_TMA  = 2'd2;
   localparam logic [1:0] REG_TAC  = 2'd3;

   // prescaler periods
   localparam logic [8:0]  DIV_PERIOD   = 9'd256;
   localparam logic [10:0] TIM_PER_1024 = 11'd1024;
   localparam logic [10:0] TIM_PER_16   = 11'd16;
   localparam logic [10:0] TIM_PER_64   = 11'd64;
   localparam logic [10:0] TIM_PER_256  = 11'd256;

   // control byte
   localparam logic [7:0] CTRL_RESET   = 8'h04;
   localparam int         CTRL_EN_BIT  = 2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] elapsed_cycles;
      logic [1:0] reg_index;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_irq;
   } rsp_type;

   // counter prescaler period from control bits 1:0
   function automatic logic [10:0] timer_period(input logic [1:0] sel);
      logic [10:0] per;
      case (sel)
         2'd0:    per = TIM_PER_1024;
         2'd1:    per = TIM_PER_16;
         2'd2:    per = TIM_PER_64;
         default: per = TIM_PER_256;
      endcase
      return per;
   endfunction

endpackage

@@ src/dmt_core.sv @@
module dmt_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  dmt_pkg::req_type  req,
   output dmt_pkg::rsp_type  rsp
);

   logic [7:0]  div_count_ff, div_count_in;
   logic [8:0]  div_rem_ff, div_rem_in;
   logic [7:0]  tim_count_ff, tim_count_in;
   logic [7:0]  tim_mod_ff, tim_mod_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [10:0] tim_rem_ff, tim_rem_in;

   logic        div_hit;
   logic        tim_hit;
   logic        tim_en;

   // prescaler compares
   assign tim_en  = ctrl_ff[dmt_pkg::CTRL_EN_BIT];
   assign div_hit = div_rem_ff <= {1'b0, req.elapsed_cycles};
   assign tim_hit = tim_rem_ff <= {3'b000, req.elapsed_cycles};

   // next state and result for the item in hand
   always_comb begin
      div_count_in  = div_count_ff;
      div_rem_in    = div_rem_ff;
      tim_count_in  = tim_count_ff;
      tim_mod_in    = tim_mod_ff;
      ctrl_in       = ctrl_ff;
      tim_rem_in    = tim_rem_ff;
      rsp.read_data = '0;
      rsp.timer_irq = 1'b0;
      case (req.cmd)
         dmt_pkg::CMD_TICK: begin
            if (tim_en) begin
               if (tim_hit) begin
                  tim_rem_in = dmt_pkg::timer_period(ctrl_ff[1:0]);
                  if (tim_count_ff == 8'hFF) begin
                     tim_count_in  = tim_mod_ff;
                     rsp.timer_irq = 1'b1;
                  end else begin
                     tim_count_in = tim_count_ff + 8'd1;
                  end
               end else begin
                  tim_rem_in = tim_rem_ff - {3'b000, req.elapsed_cycles};
               end
            end
            if (div_hit) begin
               div_rem_in   = dmt_pkg::DIV_PERIOD;
               div_count_in = div_count_ff + 8'd1;
            end else begin
               div_rem_in = div_rem_ff - {1'b0, req.elapsed_cycles};
            end
         end
         dmt_pkg::CMD_READ: begin
            case (req.reg_index)
               dmt_pkg::REG_DIV:  rsp.read_data = div_count_ff;
               dmt_pkg::REG_TIMA: rsp.read_data = tim_count_ff;
               dmt_pkg::REG_TMA:  rsp.read_data = tim_mod_ff;
               default:           rsp.read_data = ctrl_ff;
            endcase
         end
         dmt_pkg::CMD_WRITE: begin
            case (req.reg_index)
               dmt_pkg::REG_DIV:  div_count_in = '0;
               dmt_pkg::REG_TIMA: tim_count_in = req.write_data;
               dmt_pkg::REG_TMA:  tim_mod_in   = req.write_data;
               default: begin
                  ctrl_in = req.write_data;
                  // new period selection restarts the prescaler
                  if (req.write_data[1:0] != ctrl_ff[1:0]) begin
                     tim_rem_in = dmt_pkg::timer_period(req.write_data[1:0]);
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   // timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         div_count_ff <= '0;
         div_rem_ff   <= dmt_pkg::DIV_PERIOD;
         tim_count_ff <= '0;
         tim_mod_ff   <= '0;
         ctrl_ff      <= dmt_pkg::CTRL_RESET;
         tim_rem_ff   <= dmt_pkg::timer_period(dmt_pkg::CTRL_RESET[1:0]);
      end else if (step_en) begin
         div_count_ff <= div_count_in;
         div_rem_ff   <= div_rem_in;
         tim_count_ff <= tim_count_in;
         tim_mod_ff   <= tim_mod_in;
         ctrl_ff      <= ctrl_in;
         tim_rem_ff   <= tim_rem_in;
      end
   end

endmodule

@@ src/divider_and_modulo_timer_top.sv @@
// A request passes the request register, then the result register, and waits in
// either while the output is blocked. The core updates all timer state together.
// Throughput: one item per cycle unless the output stalls.
// Reset: synchronous, active high; empties both registers and sets divider and
// counter to zero, modulo to zero, control to 0x04, prescalers to full period.
module divider_and_modulo_timer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dmt_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dmt_pkg::rsp_type  rsp_payload
);

   logic              in_valid_ff;
   dmt_pkg::req_type  in_data_ff;
   logic              out_valid_ff;
   dmt_pkg::rsp_type  out_data_ff;
   dmt_pkg::rsp_type  core_rsp;
   logic              out_free;
   logic              advance;

   // stage moves when the result slot is empty or being emptied
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   dmt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (in_data_ff),
      .rsp     (core_rsp)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // a processed item always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed item not presented");

   // stall only when both stages are full and the output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request stalled without cause");

   // an interrupt result never carries read data
   a_irq_no_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.timer_irq) |-> (out_data_ff.read_data == 8'd0))
      else $error("interrupt with read data");

   // a result is only produced from a held request
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(out_valid_ff)) |-> $past(in_valid_ff))
      else $error("result without request");

endmodule

@@ bench/divider_and_modulo_timer_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels, predicts each result from the accepted requests and
// compares every result transfer against the oldest prediction.
module divider_and_modulo_timer_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  dmt_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  dmt_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               outstanding,
   output int               overflow_count
);

   // predicted timer state
   logic [7:0]  div_count;
   logic [8:0]  div_left;
   logic [7:0]  tima;
   logic [7:0]  tma;
   logic [7:0]  tac;
   logic [10:0] tima_left;

   dmt_pkg::rsp_type pending_q[$];
   int               fails;
   int               overflows;
   int               rsp_index;

   // counter prescaler period for control bits 1:0
   function automatic logic [10:0] period_for(input logic [1:0] sel);
      logic [10:0] per;
      case (sel)
         2'd0:    per = dmt_pkg::TIM_PER_1024;
         2'd1:    per = dmt_pkg::TIM_PER_16;
         2'd2:    per = dmt_pkg::TIM_PER_64;
         default: per = dmt_pkg::TIM_PER_256;
      endcase
      return per;
   endfunction

   // apply one request to the predicted state, return its result
   function automatic dmt_pkg::rsp_type timer_step(input dmt_pkg::req_type r);
      dmt_pkg::rsp_type o;
      o = '0;
      case (r.cmd)
         dmt_pkg::CMD_TICK: begin
            // counter prescaler only runs while enabled; excess cycles dropped
            if (tac[dmt_pkg::CTRL_EN_BIT]) begin
               if (tima_left <= 11'(r.elapsed_cycles)) begin
                  tima_left = period_for(tac[1:0]);
                  if (tima == 8'hFF) begin
                     tima        = tma;
                     o.timer_irq = 1'b1;
                  end else begin
                     tima = tima + 8'd1;
                  end
               end else begin
                  tima_left = tima_left - 11'(r.elapsed_cycles);
               end
            end
            // divider never stops
            if (div_left <= 9'(r.elapsed_cycles)) begin
               div_left  = dmt_pkg::DIV_PERIOD;
               div_count = div_count + 8'd1;
            end else begin
               div_left = div_left - 9'(r.elapsed_cycles);
            end
         end
         dmt_pkg::CMD_READ: begin
            case (r.reg_index)
               dmt_pkg::REG_DIV:  o.read_data = div_count;
               dmt_pkg::REG_TIMA: o.read_data = tima;
               dmt_pkg::REG_TMA:  o.read_data = tma;
               default:           o.read_data = tac;
            endcase
         end
         dmt_pkg::CMD_WRITE: begin
            case (r.reg_index)
               dmt_pkg::REG_DIV:  div_count = '0;   // any value clears, prescaler kept
               dmt_pkg::REG_TIMA: tima = r.write_data;
               dmt_pkg::REG_TMA:  tma = r.write_data;
               default: begin
                  // reload only when the period selection changes
                  if (r.write_data[1:0] != tac[1:0])
                     tima_left = period_for(r.write_data[1:0]);
                  tac = r.write_data;
               end
            endcase
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic note_failure(input string msg);
      fails++;
      if (fails <= 10)
         $display("[%0t] %s", $time, msg);
   endtask

   // pop before push: a result can never belong to the request of the same edge
   always @(posedge clock) begin : watch
      dmt_pkg::rsp_type want;
      if (reset) begin
         div_count = '0;
         div_left  = dmt_pkg::DIV_PERIOD;
         tima      = '0;
         tma       = '0;
         tac       = dmt_pkg::CTRL_RESET;
         tima_left = period_for(dmt_pkg::CTRL_RESET[1:0]);
         pending_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_payload.timer_irq === 1'b1)
               overflows++;
            if (pending_q.size() == 0) begin
               note_failure($sformatf(
                  "result %0d with nothing predicted: read_data %02h irq %0b",
                  rsp_index, rsp_payload.read_data, rsp_payload.timer_irq));
            end else begin
               want = pending_q.pop_front();
               if (rsp_payload.read_data !== want.read_data ||
                   rsp_payload.timer_irq !== want.timer_irq)
                  note_failure($sformatf({"result %0d: expected read_data %02h irq %0b, ",
                                          "got read_data %02h irq %0b"},
                                         rsp_index, want.read_data, want.timer_irq,
                                         rsp_payload.read_data, rsp_payload.timer_irq));
            end
            rsp_index++;
         end
         if (req_valid && req_ready)
            pending_q.push_back(timer_step(req_payload));
      end
      outstanding    <= pending_q.size();
      fail_count     <= fails;
      overflow_count <= overflows;
   end

endmodule

@@ bench/divider_and_modulo_timer_top_test.sv @@
`timescale 1ns / 100ps

module divider_and_modulo_timer_top_test;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;   // cycles with no transfer on either side
   localparam int HOLD_CYCLES = 80;
   localparam int PER_PHASE   = 150;

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   dmt_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   dmt_pkg::rsp_type rsp_payload;

   int      fail_count;
   int      outstanding;
   int      overflow_count;
   int      idle_pct  = 0;
   int      stall_pct = 0;
   int      hold_seq  = 0;
   int      sent      = 0;
   int      cmd_seen[4] = '{0, 0, 0, 0};

   divider_and_modulo_timer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   divider_and_modulo_timer_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .overflow_count (overflow_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin : receiver
      int hold_seen;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ends the run if nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic dmt_pkg::req_type make_item(input logic [1:0] cmd,
                                                  input logic [7:0] cycles,
                                                  input logic [1:0] idx,
                                                  input logic [7:0] data);
      dmt_pkg::req_type r;
      r.cmd            = cmd;
      r.elapsed_cycles = cycles;
      r.reg_index      = idx;
      r.write_data     = data;
      return r;
   endfunction

   // mostly ticks and writes that keep the counter running and near overflow
   function automatic dmt_pkg::req_type random_item();
      dmt_pkg::req_type r;
      int               pick;
      r.elapsed_cycles = 8'($urandom);
      r.reg_index      = 2'($urandom);
      r.write_data     = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 50)      r.cmd = dmt_pkg::CMD_TICK;
      else if (pick < 70) r.cmd = dmt_pkg::CMD_READ;
      else if (pick < 95) r.cmd = dmt_pkg::CMD_WRITE;
      else                r.cmd = CMD_UNUSED;
      if (r.cmd == dmt_pkg::CMD_TICK) begin
         case ($urandom_range(3))
            0:       r.elapsed_cycles = 8'($urandom_range(20));
            1:       r.elapsed_cycles = 8'($urandom_range(80));
            2:       r.elapsed_cycles = 8'($urandom_range(255));
            default: r.elapsed_cycles = 8'($urandom_range(255, 250));
         endcase
      end else if (r.cmd == dmt_pkg::CMD_WRITE) begin
         case (r.reg_index)
            dmt_pkg::REG_TAC:
               if ($urandom_range(99) < 80) r.write_data[dmt_pkg::CTRL_EN_BIT] = 1'b1;
            dmt_pkg::REG_TIMA:
               if ($urandom_range(99) < 60) r.write_data = 8'($urandom_range(255, 240));
            dmt_pkg::REG_TMA:
               if ($urandom_range(99) < 50) r.write_data = 8'($urandom_range(255, 224));
            default: ;
         endcase
      end
      return r;
   endfunction

   // offer one item until transferred, then maybe idle
   task automatic send_item(input dmt_pkg::req_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      cmd_seen[item.cmd]++;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // hold the sender until every predicted result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int idle_by_phase[4];
      int stall_by_phase[4];
      idle_by_phase  = '{0, 49, 0, 38};
      stall_by_phase = '{0, 0, 49, 38};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, prescaler edges, overflow and reload
      send_item(make_item(dmt_pkg::CMD_READ,  8'd0,   dmt_pkg::REG_DIV,  8'd0));
      send_item(make_item(dmt_pkg::CMD_READ,  8'd0,   dmt_pkg::REG_TIMA, 8'd0));
      send_item(make_item(dmt_pkg::CMD_READ,  8'd0,   dmt_pkg::REG_TMA,  8'd0));
      send_item(make_item(dmt_pkg::CMD_READ,  8'd0,   dmt_pkg::REG_TAC,  8'd0));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd0,   dmt_pkg::REG_DIV,  8'd0));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd255, dmt_pkg::REG_DIV,  8'd0));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd1,   dmt_pkg::REG_DIV,  8'd0));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd255, dmt_pkg::REG_DIV,  8'd0));
      send_item(make_item(dmt_pkg::CMD_WRITE, 8'd0,   dmt_pkg::REG_TAC,  8'h05));
      send_item(make_item(dmt_pkg::CMD_WRITE, 8'd0,   dmt_pkg::REG_TMA,  8'hFF));
      send_item(make_item(dmt_pkg::CMD_WRITE, 8'd0,   dmt_pkg::REG_TIMA, 8'hFE));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd16,  dmt_pkg::REG_DIV,  8'd0));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd20,  dmt_pkg::REG_DIV,  8'd0));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd15,  dmt_pkg::REG_DIV,  8'd0));
      // same period selection keeps the remaining cycles
      send_item(make_item(dmt_pkg::CMD_WRITE, 8'd0,   dmt_pkg::REG_TAC,  8'h05));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd1,   dmt_pkg::REG_DIV,  8'd0));
      // divider write clears whatever value is written
      send_item(make_item(dmt_pkg::CMD_WRITE, 8'd0,   dmt_pkg::REG_DIV,  8'hA5));
      send_item(make_item(dmt_pkg::CMD_READ,  8'd0,   dmt_pkg::REG_DIV,  8'd0));
      // counter disabled: prescaler holds
      send_item(make_item(dmt_pkg::CMD_WRITE, 8'd0,   dmt_pkg::REG_TAC,  8'h02));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd255, dmt_pkg::REG_DIV,  8'd0));
      send_item(make_item(dmt_pkg::CMD_READ,  8'd0,   dmt_pkg::REG_TIMA, 8'd0));
      send_item(make_item(dmt_pkg::CMD_WRITE, 8'd0,   dmt_pkg::REG_TAC,  8'hFF));
      send_item(make_item(dmt_pkg::CMD_READ,  8'd0,   dmt_pkg::REG_TAC,  8'd0));
      // unused command with every field bit set
      send_item(make_item(CMD_UNUSED,         8'hFF,  dmt_pkg::REG_TAC,  8'hFF));
      send_item(make_item(dmt_pkg::CMD_TICK,  8'd255, dmt_pkg::REG_TAC,  8'hFF));
      wait_drain();

      // random phases with different idling on each side
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct   = idle_by_phase[phase];
         stall_pct <= stall_by_phase[phase];
         for (int n = 0; n < PER_PHASE; n++) begin
            if (phase == 0 && n == 40)
               hold_seq <= hold_seq + 1;
            if (n == PER_PHASE / 2)
               wait_drain();
            send_item(random_item());
         end
         wait_drain();
      end

      repeat (8) @(posedge clock);

      $display("covered %0d items: %0d ticks, %0d reads, %0d writes, %0d unused commands",
               sent, cmd_seen[dmt_pkg::CMD_TICK], cmd_seen[dmt_pkg::CMD_READ],
               cmd_seen[dmt_pkg::CMD_WRITE], cmd_seen[CMD_UNUSED]);
      $display("%0d counter overflow interrupts; idling on neither, either and both sides%s",
               overflow_count, ", one long hold-off");
      if (fail_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
